/* hw/rtl/spcc_pkg.sv */
// Package: command, status and life state codes for the PIN/PUK command checker.
`timescale 1ns / 1ps

package spcc_pkg;

  // Widths of the command and response words
  localparam int BYTE_W    = 8;
  localparam int CODE_W    = 64;
  localparam int STORE_W   = 32;
  localparam int STATUS_W  = 3;
  localparam int TRIES_W   = 2;
  localparam int EXPLEN_W  = 5;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [STORE_W-1:0]  store_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [TRIES_W-1:0]  tries_t;
  typedef logic [EXPLEN_W-1:0] explen_t;
  typedef logic [1:0]          life_t;

  // Class and instruction bytes
  localparam byte_t CLA_GSM     = 8'hA0;
  localparam byte_t INS_VERIFY  = 8'h20;
  localparam byte_t INS_CHANGE  = 8'h24;
  localparam byte_t INS_UNBLOCK = 8'h2C;
  localparam byte_t INS_SET_PUK = 8'h40;

  // ASCII digit range
  localparam byte_t ASCII_ZERO = 8'h30;
  localparam byte_t ASCII_NINE = 8'h39;

  // Response status codes
  localparam status_t RS_OK         = 3'd0;
  localparam status_t RS_WRONG_CODE = 3'd1;
  localparam status_t RS_WRONG_LEN  = 3'd2;
  localparam status_t RS_BAD_INS    = 3'd3;
  localparam status_t RS_BAD_DATA   = 3'd4;

  // Card life states
  localparam life_t ST_BLANK    = 2'd0;
  localparam life_t ST_LOCKED   = 2'd1;
  localparam life_t ST_UNLOCKED = 2'd2;
  localparam life_t ST_BLOCKED  = 2'd3;

endpackage

/* hw/rtl/spcc_if.sv */
// Interfaces: command word channel and response word channel.
`timescale 1ns / 1ps

interface spcc_cmd_if import spcc_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t class_byte;
  byte_t action;
  byte_t command_length;
  code_t first_code;
  code_t second_code;

  modport source (output valid, class_byte, action, command_length, first_code, second_code,
                  input ready);
  modport sink   (input valid, class_byte, action, command_length, first_code, second_code,
                  output ready);
endinterface

interface spcc_rsp_if import spcc_pkg::*;;
  logic    valid;
  logic    ready;
  status_t status;
  tries_t  tries_left;
  explen_t expected_length;
  logic    data_accepted;

  modport source (output valid, status, tries_left, expected_length, data_accepted,
                  input ready);
  modport sink   (input valid, status, tries_left, expected_length, data_accepted,
                  output ready);
endinterface

/* hw/rtl/spcc_code_pack.sv */
// Code packer: ASCII code bytes to packed decimal nibbles with a digit check.
`timescale 1ns / 1ps

module spcc_code_pack import spcc_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  code_t                 code,
  output logic [4*DIGITS-1:0]   digits,
  output logic                  ok
);

  // Each byte is checked on its own; a non-digit packs as zero
  always_comb begin
    byte_t b;
    ok     = 1'b1;
    digits = '0;
    for (int i = 0; i < DIGITS; i++) begin
      b = code[CODE_W-1-BYTE_W*i -: BYTE_W];
      if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
        digits[4*(DIGITS-1-i) +: 4] = b[3:0];
      end else begin
        ok = 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/sim_pin_puk_command_checker_top.sv */
// Top level: SIM PIN/PUK command checker with card life state and stored codes.
//
// Usage:
//   in_cmd  carries one card command word: class, instruction, announced length
//           and two ASCII codes (first received byte in the top bits).
//   out_rsp carries one response word per command: status, tries left,
//           expected length and a data-accepted flag.
//   Both channels use valid/ready; a word moves when both are high.
// Timing:
//   A command is held in the input register; its response is loaded into the
//   output register once that register is empty or being read, and is then
//   valid until out_rsp.ready takes it. One command per cycle is sustained
//   while out_rsp.ready stays high; the card state (life state, retry
//   counter, PIN, PUK) is updated at the same edge that loads the response.
// Reset (rst_n low, synchronous): the card goes blank with zero retries and
//   erased PIN and PUK stores; both channels go empty.
// Stall: while out_rsp.ready is low a waiting response holds, the command in
//   the input register waits, and in_cmd.ready drops once that register is full.
`timescale 1ns / 1ps

module sim_pin_puk_command_checker_top import spcc_pkg::*; #(
  parameter int CODE_DIGITS = 8,
  parameter int RETRY_LIMIT = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  spcc_cmd_if.sink    in_cmd,
  spcc_rsp_if.source  out_rsp
);

  localparam int    PACK_W     = 4 * CODE_DIGITS;
  localparam byte_t LEN_SHORT  = byte_t'(CODE_DIGITS);
  localparam byte_t LEN_LONG   = byte_t'(2 * CODE_DIGITS);
  localparam life_t RETRY_FULL = life_t'(RETRY_LIMIT);

  // Input register
  logic  cmd_vld_r;
  byte_t class_r, action_r, len_r;
  code_t code1_r, code2_r;

  // Response register
  logic    rsp_vld_r;
  status_t status_r;
  tries_t  tries_r;
  explen_t explen_r;
  logic    acc_r;

  // Card state
  life_t  life_r, life_nxt;
  tries_t retry_r, retry_nxt;
  store_t pin_r, pin_nxt;
  store_t puk_r, puk_nxt;

  status_t status_nxt;
  tries_t  tries_nxt, retry_dec;
  explen_t explen_nxt;
  logic    acc_nxt;
  life_t   need_state;
  byte_t   need_len;
  logic    ins_known;

  logic [PACK_W-1:0] d1, d2;
  logic              ok1, ok2;

  logic rsp_load, advance, in_take;

  // Handshake
  assign rsp_load     = !rsp_vld_r || out_rsp.ready;
  assign advance      = cmd_vld_r && rsp_load;
  assign in_cmd.ready = !cmd_vld_r || rsp_load;
  assign in_take      = in_cmd.valid && in_cmd.ready;

  // Digit packers for both codes
  spcc_code_pack #(.DIGITS(CODE_DIGITS)) u_pack1 (.code(code1_r), .digits(d1), .ok(ok1));
  spcc_code_pack #(.DIGITS(CODE_DIGITS)) u_pack2 (.code(code2_r), .digits(d2), .ok(ok2));

  assign retry_dec = (retry_r != '0) ? retry_r - tries_t'(1) : '0;

  // Command decode and card state update
  always_comb begin
    status_nxt = RS_OK;
    tries_nxt  = '0;
    explen_nxt = '0;
    acc_nxt    = 1'b0;
    life_nxt   = life_r;
    retry_nxt  = retry_r;
    pin_nxt    = pin_r;
    puk_nxt    = puk_r;
    need_state = ST_BLANK;
    need_len   = LEN_SHORT;
    ins_known  = 1'b1;

    unique case (action_r)
      INS_VERIFY:  begin need_state = ST_LOCKED;   need_len = LEN_SHORT; end
      INS_CHANGE:  begin need_state = ST_UNLOCKED; need_len = LEN_LONG;  end
      INS_UNBLOCK: begin need_state = ST_BLOCKED;  need_len = LEN_LONG;  end
      INS_SET_PUK: begin need_state = ST_BLANK;    need_len = LEN_SHORT; end
      default:     ins_known = 1'b0;
    endcase

    priority if (class_r != CLA_GSM) begin
      status_nxt = RS_BAD_DATA;
    end else if (!ins_known || life_r != need_state) begin
      status_nxt = RS_BAD_INS;
    end else if (len_r != need_len) begin
      status_nxt = RS_WRONG_LEN;
      explen_nxt = need_len[EXPLEN_W-1:0];
    end else begin
      acc_nxt = 1'b1;
      priority if (action_r == INS_SET_PUK) begin
        if (!ok1) begin
          status_nxt = RS_BAD_DATA;
        end else begin
          puk_nxt   = store_t'(d1);
          retry_nxt = RETRY_FULL;
          life_nxt  = ST_LOCKED;
        end
      end else if (action_r == INS_UNBLOCK) begin
        if (!ok1 || d1 != puk_r[PACK_W-1:0] || !ok2) begin
          status_nxt = RS_BAD_DATA;
        end else begin
          pin_nxt   = store_t'(d2);
          retry_nxt = RETRY_FULL;
          life_nxt  = ST_UNLOCKED;
        end
      end else if (!ok1 || d1 != pin_r[PACK_W-1:0]) begin
        // Wrong PIN: count down, block at zero
        retry_nxt  = retry_dec;
        tries_nxt  = retry_dec;
        status_nxt = RS_WRONG_CODE;
        if (retry_dec == '0) begin
          life_nxt = ST_BLOCKED;
        end
      end else begin
        retry_nxt = RETRY_FULL;
        priority if (action_r == INS_VERIFY) begin
          life_nxt = ST_UNLOCKED;
        end else if (!ok2) begin
          status_nxt = RS_BAD_DATA;
        end else begin
          pin_nxt = store_t'(d2);
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else if (in_take) begin
      cmd_vld_r <= 1'b1;
    end else if (advance) begin
      cmd_vld_r <= 1'b0;
    end
    if (in_take) begin
      class_r <= in_cmd.class_byte;
      action_r <= in_cmd.action;
      len_r   <= in_cmd.command_length;
      code1_r <= in_cmd.first_code;
      code2_r <= in_cmd.second_code;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_vld_r <= 1'b0;
    end else if (advance) begin
      rsp_vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      rsp_vld_r <= 1'b0;
    end
    if (advance) begin
      status_r <= status_nxt;
      tries_r  <= tries_nxt;
      explen_r <= explen_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // Card state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r  <= ST_BLANK;
      retry_r <= '0;
      pin_r   <= '1;
      puk_r   <= '1;
    end else if (advance) begin
      life_r  <= life_nxt;
      retry_r <= retry_nxt;
      pin_r   <= pin_nxt;
      puk_r   <= puk_nxt;
    end
  end

  assign out_rsp.valid           = rsp_vld_r;
  assign out_rsp.status          = status_r;
  assign out_rsp.tries_left      = tries_r;
  assign out_rsp.expected_length = explen_r;
  assign out_rsp.data_accepted   = acc_r;

  // Checks
  a_blocked_no_tries: assert property (@(posedge clk) disable iff (!rst_n)
    (life_r == ST_BLOCKED || life_r == ST_BLANK) |-> retry_r == '0)
    else $error("retry counter nonzero while blank or blocked");

  a_retry_limit: assert property (@(posedge clk) disable iff (!rst_n)
    retry_r <= RETRY_FULL)
    else $error("retry counter above limit");

  a_explen_only_len: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_vld_r && status_r != RS_WRONG_LEN) |-> explen_r == '0)
    else $error("expected length set without length error");

  a_tries_only_wrong: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_vld_r && status_r != RS_WRONG_CODE) |-> tries_r == '0)
    else $error("tries left set without wrong code");

  a_accept_status: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_vld_r && acc_r) |-> (status_r != RS_WRONG_LEN && status_r != RS_BAD_INS))
    else $error("data accepted with header error");

  a_state_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(life_r) && $stable(retry_r))
    else $error("card state changed without a command");

endmodule
